### rtl/core/frrp_pkg.sv
// Shared types and constants for the flash record ring pointer.
// Field widths, transaction codes, sequencer states and parameter defaults.
// No dependencies.
package frrp_pkg;

   // default geometry
   localparam int DEF_CHANNELS          = 128;
   localparam int DEF_MAX_RECORDS       = 1024;
   localparam int DEF_ERASE_BLOCK_BYTES = 4096;

   // field widths
   localparam int KIND_W     = 2;
   localparam int CHAN_W     = 7;
   localparam int AGE_W      = 10;
   localparam int OFF_W      = 12;
   localparam int MAXREC_W   = 11;
   localparam int REC_W      = 13;
   localparam int ADDR_W     = 32;
   localparam int MODE_W     = 2;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 88;   // 87 bits of fields, padded to whole bytes

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'd0,
      KIND_LOCATE = 2'd1,
      KIND_LOAD   = 2'd2,
      KIND_NOP    = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_UNLOADED = 2'd2,
      STAT_RSVD     = 2'd3
   } status_type;

   localparam logic [MODE_W-1:0] MODE_ERASE = 2'd0;   // cut to max - rpb when full
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd1;   // never cut
   localparam logic [MODE_W-1:0] MODE_HALF  = 2'd2;   // cut to max/2

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOOK = 7'b0000010,
      S_RPB  = 7'b0000100,
      S_MOD  = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_ADD  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

endpackage

### rtl/core/frrp_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Shared by the ring pointer sequencer; no package dependencies.
module frrp_div #(
   parameter int W = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);

   localparam int CNT_W = $clog2(W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     den_ff, den_in;
   logic [W:0]       shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quo_ff[W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = W'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### rtl/core/flash_record_ring_pointer.sv
// Flash record ring pointer: top level, sequencer, descriptor and ring stores.
// Depends on frrp_pkg and frrp_div.
//
// Usage
//   req_ channel: one transaction per command. tuser carries the kind
//   (append, locate, load descriptor, no-op). tdata carries channel, age index, byte
//   offset and the descriptor fields used by a load.
//   rsp_ channel: exactly one transaction per command, in order. tuser is the
//   status, tdata the flash byte address (0 on error, load or no-op).
// Sequence (accept to rsp_tvalid)
//   load, no-op or error: lookup, then output; locate: lookup, multiply, add,
//   output. Append in modes 0/2 with record length up to the erase block:
//   the shared bit-serial divider runs once for records-per-block and once
//   for head modulo that, then multiply, add, output.
//   Other appends: lookup, multiply, add, output.
// Throughput: one command at a time; req_tready is high only while the
//   sequencer is idle. A finished result sits in the rsp_ register, so the
//   next command may be accepted and worked on while it waits.
// Reset: clears the sequencer, the response valid flag and every channel's
//   loaded flag; descriptors and ring state need no clearing pass.
// Stall: a held rsp_ transaction holds the sequencer in its output state.
module flash_record_ring_pointer #(
   parameter int CHANNELS          = frrp_pkg::DEF_CHANNELS,
   parameter int MAX_RECORDS       = frrp_pkg::DEF_MAX_RECORDS,
   parameter int ERASE_BLOCK_BYTES = frrp_pkg::DEF_ERASE_BLOCK_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] channel, [16:7] age_index, [28:17] byte_offset,
   // [39:29] desc_max_records, [52:40] desc_record_len,
   // [84:53] desc_base_addr, [86:85] desc_mode, [87] zero
   input  logic [frrp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [frrp_pkg::KIND_W-1:0]     req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [frrp_pkg::ADDR_W-1:0]     rsp_tdata,   // [31:0] address
   output logic [frrp_pkg::STAT_W-1:0]     rsp_tuser    // [1:0] status
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W = $clog2(MAX_RECORDS + 1);
   localparam int EBB_W  = $clog2(ERASE_BLOCK_BYTES + 1);
   localparam int DIV_W  = (EBB_W > SLOT_W) ? EBB_W : SLOT_W;
   localparam int SUM_W  = ((SLOT_W > frrp_pkg::AGE_W) ? SLOT_W : frrp_pkg::AGE_W) + 1;
   localparam int PROD_W = SLOT_W + frrp_pkg::REC_W;

   // request fields
   logic [frrp_pkg::CHAN_W-1:0]   f_chan;
   logic [frrp_pkg::AGE_W-1:0]    f_age;
   logic [frrp_pkg::OFF_W-1:0]    f_off;
   logic [frrp_pkg::MAXREC_W-1:0] f_max;
   logic [frrp_pkg::REC_W-1:0]    f_len;
   logic [frrp_pkg::ADDR_W-1:0]   f_base;
   logic [frrp_pkg::MODE_W-1:0]   f_mode;

   assign f_chan = req_tdata[6:0];
   assign f_age  = req_tdata[16:7];
   assign f_off  = req_tdata[28:17];
   assign f_max  = req_tdata[39:29];
   assign f_len  = req_tdata[52:40];
   assign f_base = req_tdata[84:53];
   assign f_mode = req_tdata[86:85];

   // stores
   logic [SLOT_W-1:0]            slots_mem [CHANNELS];
   logic [frrp_pkg::REC_W-1:0]   len_mem   [CHANNELS];
   logic [frrp_pkg::MODE_W-1:0]  mode_mem  [CHANNELS];
   logic [frrp_pkg::ADDR_W-1:0]  base_mem  [CHANNELS];
   logic [SLOT_W-1:0]            head_mem  [CHANNELS];
   logic [SLOT_W-1:0]            count_mem [CHANNELS];
   logic [CHANNELS-1:0]          loaded_ff, loaded_in;

   // sequencer and item registers
   frrp_pkg::state_type          state_ff, state_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [frrp_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   frrp_pkg::status_type         rsp_stat_ff, rsp_stat_in;

   frrp_pkg::kind_type           kind_ff;
   logic [CH_W-1:0]              ch_ff;
   logic                         inrange_ff, hit_ff;
   logic [frrp_pkg::AGE_W-1:0]   age_ff;
   logic [frrp_pkg::OFF_W-1:0]   off_ff;
   logic [frrp_pkg::MAXREC_W-1:0] ld_max_ff;
   logic [frrp_pkg::REC_W-1:0]   ld_len_ff;
   logic [frrp_pkg::ADDR_W-1:0]  ld_base_ff;
   logic [frrp_pkg::MODE_W-1:0]  ld_mode_ff;

   logic [SLOT_W-1:0]            rd_slots_ff, rd_head_ff, rd_count_ff;
   logic [frrp_pkg::REC_W-1:0]   rd_len_ff;
   logic [frrp_pkg::MODE_W-1:0]  rd_mode_ff;
   logic [frrp_pkg::ADDR_W-1:0]  rd_base_ff;

   logic [SLOT_W-1:0]            slot_ff, slot_in;
   logic [SLOT_W-1:0]            count_ff, count_in;
   logic [DIV_W-1:0]             rpb_ff, rpb_in;
   logic [PROD_W-1:0]            prod_ff, prod_in;
   logic [frrp_pkg::ADDR_W-1:0]  res_addr_ff, res_addr_in;
   frrp_pkg::status_type         res_stat_ff, res_stat_in;

   logic                         req_acc;
   logic [CH_W-1:0]              req_ch;
   logic                         req_inrange;

   // divider link
   logic                         div_start, div_done;
   logic [DIV_W-1:0]             div_num, div_den, div_quo, div_rem;

   // combinational helpers
   logic [SLOT_W-1:0]            new_head, new_count, ld_slots;
   logic [frrp_pkg::REC_W-1:0]   len_nz;
   logic                         cut_able;
   logic [SUM_W-1:0]             loc_sum;
   logic                         ld_wr, ring_wr;
   logic [SLOT_W-1:0]            ring_head_wr, ring_count_wr;
   logic [SLOT_W-1:0]            half_n;

   assign req_tready  = (state_ff == frrp_pkg::S_IDLE);
   assign req_acc     = req_tvalid && req_tready;
   assign req_ch      = CH_W'(f_chan);
   assign req_inrange = (9'(f_chan) < 9'(CHANNELS));

   // item capture and store reads
   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff     <= frrp_pkg::kind_type'(req_tuser);
         ch_ff       <= req_ch;
         inrange_ff  <= req_inrange;
         hit_ff      <= req_inrange && loaded_ff[req_ch];
         age_ff      <= f_age;
         off_ff      <= f_off;
         ld_max_ff   <= f_max;
         ld_len_ff   <= f_len;
         ld_base_ff  <= f_base;
         ld_mode_ff  <= f_mode;
         rd_slots_ff <= slots_mem[req_ch];
         rd_len_ff   <= len_mem[req_ch];
         rd_mode_ff  <= mode_mem[req_ch];
         rd_base_ff  <= base_mem[req_ch];
         rd_head_ff  <= head_mem[req_ch];
         rd_count_ff <= count_mem[req_ch];
      end
   end

   // load descriptor: zero slots taken as one, saturate at MAX_RECORDS
   always_comb begin
      if (ld_max_ff == '0) begin
         ld_slots = SLOT_W'(1);
      end else if (32'(ld_max_ff) > 32'(MAX_RECORDS)) begin
         ld_slots = SLOT_W'(MAX_RECORDS);
      end else begin
         ld_slots = SLOT_W'(ld_max_ff);
      end
   end

   assign ld_wr   = (state_ff == frrp_pkg::S_LOOK) && (kind_ff == frrp_pkg::KIND_LOAD)
                    && inrange_ff;
   assign ring_wr = ld_wr || ((state_ff == frrp_pkg::S_MUL)
                    && (kind_ff == frrp_pkg::KIND_APPEND));
   assign ring_head_wr  = ld_wr ? '0 : slot_ff;
   assign ring_count_wr = ld_wr ? '0 : count_ff;

   always_ff @(posedge clock) begin
      if (ld_wr) begin
         slots_mem[ch_ff] <= ld_slots;
         len_mem[ch_ff]   <= ld_len_ff;
         mode_mem[ch_ff]  <= ld_mode_ff;
         base_mem[ch_ff]  <= ld_base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_wr) begin
         head_mem[ch_ff]  <= ring_head_wr;
         count_mem[ch_ff] <= ring_count_wr;
      end
   end

   // append: head steps back one slot, count saturates at the slot count
   assign new_head  = (rd_head_ff == '0) ? SLOT_W'(rd_slots_ff - 1'b1)
                                        : SLOT_W'(rd_head_ff - 1'b1);
   assign new_count = (rd_count_ff < rd_slots_ff) ? SLOT_W'(rd_count_ff + 1'b1)
                                                 : rd_slots_ff;
   // record length zero counts as one byte per block step
   assign len_nz    = (rd_len_ff == '0) ? frrp_pkg::REC_W'(1) : rd_len_ff;
   assign cut_able  = ((rd_mode_ff == frrp_pkg::MODE_ERASE)
                      || (rd_mode_ff == frrp_pkg::MODE_HALF))
                      && (32'(rd_len_ff) <= 32'(ERASE_BLOCK_BYTES));
   // locate: head + age is below twice the slot count, so one subtract wraps it
   assign loc_sum   = SUM_W'(rd_head_ff) + SUM_W'(age_ff);
   assign half_n    = rd_slots_ff >> 1;

   assign div_start = ((state_ff == frrp_pkg::S_LOOK) && hit_ff
                       && (kind_ff == frrp_pkg::KIND_APPEND) && cut_able)
                      || ((state_ff == frrp_pkg::S_RPB) && div_done);
   assign div_num   = (state_ff == frrp_pkg::S_LOOK) ? DIV_W'(ERASE_BLOCK_BYTES)
                                                    : DIV_W'(slot_ff);
   assign div_den   = (state_ff == frrp_pkg::S_LOOK) ? DIV_W'(len_nz) : div_quo;

   frrp_div #(.W(DIV_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      rpb_in       = rpb_ff;
      prod_in      = prod_ff;
      res_addr_in  = res_addr_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_stat_in  = rsp_stat_ff;
      loaded_in    = loaded_ff;

      unique case (state_ff)
         frrp_pkg::S_IDLE: begin
            if (req_acc) begin
               state_in = frrp_pkg::S_LOOK;
            end
         end
         frrp_pkg::S_LOOK: begin
            res_addr_in = '0;
            res_stat_in = frrp_pkg::STAT_OK;
            state_in    = frrp_pkg::S_OUT;
            priority if (!inrange_ff) begin
               res_stat_in = frrp_pkg::STAT_UNLOADED;
            end else if (kind_ff == frrp_pkg::KIND_LOAD) begin
               loaded_in[ch_ff] = 1'b1;
            end else if (kind_ff == frrp_pkg::KIND_NOP) begin
               res_stat_in = frrp_pkg::STAT_OK;
            end else if (!hit_ff) begin
               res_stat_in = frrp_pkg::STAT_UNLOADED;
            end else if (kind_ff == frrp_pkg::KIND_APPEND) begin
               slot_in  = new_head;
               count_in = new_count;
               state_in = cut_able ? frrp_pkg::S_RPB : frrp_pkg::S_MUL;
            end else begin
               if (SUM_W'(age_ff) >= SUM_W'(rd_count_ff)) begin
                  res_stat_in = frrp_pkg::STAT_EMPTY;
               end else begin
                  slot_in  = (loc_sum >= SUM_W'(rd_slots_ff))
                             ? SLOT_W'(loc_sum - SUM_W'(rd_slots_ff))
                             : SLOT_W'(loc_sum);
                  state_in = frrp_pkg::S_MUL;
               end
            end
         end
         frrp_pkg::S_RPB: begin
            // records per erase block; never zero here
            if (div_done) begin
               rpb_in   = div_quo;
               state_in = frrp_pkg::S_MOD;
            end
         end
         frrp_pkg::S_MOD: begin
            if (div_done) begin
               state_in = frrp_pkg::S_MUL;
               if (div_rem == '0) begin
                  if (rd_mode_ff == frrp_pkg::MODE_ERASE) begin
                     if (count_ff == rd_slots_ff) begin
                        count_in = (rpb_ff >= DIV_W'(rd_slots_ff)) ? '0
                                   : SLOT_W'(DIV_W'(rd_slots_ff) - rpb_ff);
                     end
                  end else if (count_ff >= half_n) begin
                     count_in = half_n;
                  end
               end
            end
         end
         frrp_pkg::S_MUL: begin
            prod_in  = PROD_W'(slot_ff) * PROD_W'(rd_len_ff);
            state_in = frrp_pkg::S_ADD;
         end
         frrp_pkg::S_ADD: begin
            res_addr_in = rd_base_ff + frrp_pkg::ADDR_W'(prod_ff)
                          + ((kind_ff == frrp_pkg::KIND_LOCATE)
                             ? frrp_pkg::ADDR_W'(off_ff) : '0);
            res_stat_in = frrp_pkg::STAT_OK;
            state_in    = frrp_pkg::S_OUT;
         end
         frrp_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = frrp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = frrp_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frrp_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         loaded_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         loaded_ff    <= loaded_in;
      end
      slot_ff     <= slot_in;
      count_ff    <= count_in;
      rpb_ff      <= rpb_in;
      prod_ff     <= prod_in;
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_stat_ff;

   // checks
   a_head_in_ring: assert property (@(posedge clock) disable iff (reset)
      ring_wr && !ld_wr |-> slot_ff < rd_slots_ff)
      else $error("append head outside ring");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ring_wr && !ld_wr |-> count_ff <= rd_slots_ff)
      else $error("append count above slot count");

   a_rpb_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == frrp_pkg::S_MOD |-> rpb_ff != '0)
      else $error("modulo by zero records per block");

   a_load_marks: assert property (@(posedge clock) disable iff (reset)
      ld_wr |=> loaded_ff[ch_ff])
      else $error("loaded channel not flagged");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_stat_ff != frrp_pkg::STAT_RSVD)
      else $error("reserved status code on response");

endmodule

### sim/frrp_reply_checker.sv
// Reply checker for the flash record ring pointer: watches both stream channels,
// predicts each reply from its own copy of the ring state and compares in order.
// Depends on frrp_pkg.
module frrp_reply_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [frrp_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [frrp_pkg::KIND_W-1:0]      req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [frrp_pkg::ADDR_W-1:0]      rsp_tdata,
   input  logic [frrp_pkg::STAT_W-1:0]      rsp_tuser,
   output int                               fail_count,
   output int                               pending,
   output int                               checked
);
   import frrp_pkg::*;

   localparam int CHANNELS     = DEF_CHANNELS;
   localparam int MAX_RECORDS  = DEF_MAX_RECORDS;
   localparam int BLOCK_BYTES  = DEF_ERASE_BLOCK_BYTES;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  address;
   } ring_reply_t;

   // per-channel copy of descriptor and ring state
   int unsigned        slot_count [CHANNELS];
   int unsigned        rec_bytes  [CHANNELS];
   logic [MODE_W-1:0]  erase_mode [CHANNELS];
   logic [ADDR_W-1:0]  base_addr  [CHANNELS];
   int unsigned        head_slot  [CHANNELS];
   int unsigned        valid_count[CHANNELS];
   bit                 chan_loaded[CHANNELS];

   ring_reply_t replies_due[$];

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 100)
         $display("%0t: mismatch: %s", $time, msg);
   endtask

   function automatic ring_reply_t predict_reply(input logic [KIND_W-1:0] kind,
                                                 input logic [REQ_DATA_W-1:0] d);
      ring_reply_t r;
      int unsigned ch, n, rpb, slot, age;
      r.status  = STAT_OK;
      r.address = '0;
      ch  = 32'(d[6:0]);
      age = 32'(d[16:7]);
      if (ch >= CHANNELS) begin
         r.status = STAT_UNLOADED;
      end else if (kind == KIND_LOAD) begin
         n = 32'(d[39:29]);
         if (n == 0) n = 1;
         if (n > MAX_RECORDS) n = MAX_RECORDS;
         slot_count[ch]  = n;
         rec_bytes[ch]   = 32'(d[52:40]);
         base_addr[ch]   = d[84:53];
         erase_mode[ch]  = d[86:85];
         head_slot[ch]   = 0;
         valid_count[ch] = 0;
         chan_loaded[ch] = 1'b1;
      end else if (kind == KIND_NOP) begin
         // nothing changes
      end else if (!chan_loaded[ch]) begin
         r.status = STAT_UNLOADED;
      end else if (kind == KIND_APPEND) begin
         n   = slot_count[ch];
         rpb = (rec_bytes[ch] == 0) ? BLOCK_BYTES : BLOCK_BYTES / rec_bytes[ch];
         head_slot[ch] = (head_slot[ch] % n + n - 1) % n;
         if (valid_count[ch] < n) valid_count[ch]++;
         else valid_count[ch] = n;
         // count cut when the new head opens an erase block
         if (rpb != 0 && head_slot[ch] % rpb == 0) begin
            if (erase_mode[ch] == MODE_ERASE) begin
               if (valid_count[ch] == n)
                  valid_count[ch] = (rpb >= n) ? 0 : n - rpb;
            end else if (erase_mode[ch] == MODE_HALF) begin
               if (valid_count[ch] >= n / 2)
                  valid_count[ch] = n / 2;
            end
         end
         r.address = base_addr[ch] + head_slot[ch] * rec_bytes[ch];
      end else begin
         if (age >= valid_count[ch]) begin
            r.status = STAT_EMPTY;
         end else begin
            slot = (head_slot[ch] + age) % slot_count[ch];
            r.address = 32'(d[28:17]) + base_addr[ch] + slot * rec_bytes[ch];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      ring_reply_t want;
      if (reset) begin
         replies_due.delete();
         for (int i = 0; i < CHANNELS; i++) begin
            chan_loaded[i] = 1'b0;
            head_slot[i]   = 0;
            valid_count[i] = 0;
         end
      end else begin
         // reply side first: a reply never belongs to a request of the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               report_mismatch($sformatf("reply with nothing due: status %0d addr %h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = replies_due.pop_front();
               checked++;
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("status %0d, wanted %0d", rsp_tuser,
                                            want.status));
               if (rsp_tdata !== want.address)
                  report_mismatch($sformatf("address %h, wanted %h", rsp_tdata,
                                            want.address));
            end
         end
         if (req_tvalid && req_tready)
            replies_due.push_back(predict_reply(req_tuser, req_tdata));
      end
      pending = replies_due.size();
   end

endmodule

### sim/tb_flash_record_ring_pointer.sv
// Testbench top for the flash record ring pointer: clock, reset, request and
// reply stimulus with random idling, verdict. Depends on frrp_pkg, the block
// and frrp_reply_checker, which does all prediction and comparison.
module tb_flash_record_ring_pointer;
   import frrp_pkg::*;

   // mode 3 has no name in the package; it must act as "no cut"
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1050;
   localparam int POOL_SIZE    = 8;
   // settle time after the last reply
   localparam int DRAIN_CYCLES = 40;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // [6:0] channel, [16:7] age_index, [28:17] byte_offset,
   // [39:29] desc_max_records, [52:40] desc_record_len,
   // [84:53] desc_base_addr, [86:85] desc_mode, [87] zero
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [KIND_W-1:0]       req_tuser = KIND_NOP;   // [1:0] kind
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [ADDR_W-1:0]       rsp_tdata;              // [31:0] address
   logic [STAT_W-1:0]       rsp_tuser;              // [1:0] status

   int fail_count, pending, checked;
   int n_loads, n_appends, n_locates, n_nops;

   // burst flags: while set, that side does not idle at all
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   logic [CHAN_W-1:0] chan_pool [POOL_SIZE];

   flash_record_ring_pointer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   frrp_reply_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #(8 * 600000);
      $display("tb_flash_record_ring_pointer failed");
      $finish;
   end

   // One request transaction. Called at a rising edge; returns at the edge that
   // accepted it. Valid stays high straight into the next item when gap is 0.
   task automatic send_txn(input kind_type kind, input logic [REQ_DATA_W-1:0] d);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= kind;
      // ready is settled by the falling edge
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [REQ_DATA_W-1:0] pack_req(
      input logic [CHAN_W-1:0]   ch,
      input logic [AGE_W-1:0]    age,
      input logic [OFF_W-1:0]    off,
      input logic [MAXREC_W-1:0] slots,
      input logic [REC_W-1:0]    rec_len,
      input logic [ADDR_W-1:0]   base,
      input logic [MODE_W-1:0]   mode);
      return {1'b0, mode, base, rec_len, slots, off, age, ch};
   endfunction

   task automatic issue_load(input logic [CHAN_W-1:0] ch, input logic [MAXREC_W-1:0] slots,
                             input logic [REC_W-1:0] rec_len, input logic [ADDR_W-1:0] base,
                             input logic [MODE_W-1:0] mode);
      n_loads++;
      send_txn(KIND_LOAD, pack_req(ch, AGE_W'($urandom), OFF_W'($urandom), slots, rec_len,
                                   base, mode));
   endtask

   // unused fields carry noise; the block must ignore them
   task automatic issue_append(input logic [CHAN_W-1:0] ch);
      n_appends++;
      send_txn(KIND_APPEND, pack_req(ch, AGE_W'($urandom), OFF_W'($urandom),
                                     MAXREC_W'($urandom), REC_W'($urandom),
                                     $urandom, MODE_W'($urandom)));
   endtask

   task automatic issue_locate(input logic [CHAN_W-1:0] ch, input logic [AGE_W-1:0] age,
                               input logic [OFF_W-1:0] off);
      n_locates++;
      send_txn(KIND_LOCATE, pack_req(ch, age, off, MAXREC_W'($urandom), REC_W'($urandom),
                                     $urandom, MODE_W'($urandom)));
   endtask

   task automatic issue_nop(input logic [CHAN_W-1:0] ch);
      n_nops++;
      send_txn(KIND_NOP, pack_req(ch, AGE_W'($urandom), OFF_W'($urandom),
                                  MAXREC_W'($urandom), REC_W'($urandom),
                                  $urandom, MODE_W'($urandom)));
   endtask

   // Mostly small rings with block-friendly record sizes so that rings fill and
   // the erase cuts fire; now and then the full field range and the edges.
   task automatic random_load(input logic [CHAN_W-1:0] ch);
      logic [MAXREC_W-1:0] slots;
      logic [REC_W-1:0]    rec_len;
      logic [MODE_W-1:0]   mode;
      int                  pick;
      pick = $urandom_range(0, 19);
      if (pick < 14)      slots = MAXREC_W'($urandom_range(1, 16));
      else if (pick < 16) slots = MAXREC_W'($urandom_range(17, 64));
      else if (pick < 19) slots = MAXREC_W'($urandom_range(0, 2047));
      else begin
         case ($urandom_range(0, 3))
            0:       slots = 11'd0;
            1:       slots = 11'd1;
            2:       slots = 11'd1024;
            default: slots = 11'd1025;
         endcase
      end
      pick = $urandom_range(0, 19);
      if (pick < 12)      rec_len = 13'(4096 >> $urandom_range(0, 7));
      else if (pick < 15) rec_len = REC_W'($urandom_range(1, 4096));
      else if (pick < 18) rec_len = REC_W'($urandom_range(0, 8191));
      else begin
         case ($urandom_range(0, 3))
            0:       rec_len = 13'd0;
            1:       rec_len = 13'd4096;
            2:       rec_len = 13'd4097;
            default: rec_len = 13'd8191;
         endcase
      end
      pick = $urandom_range(0, 9);
      if (pick < 4)      mode = MODE_ERASE;
      else if (pick < 6) mode = MODE_NONE;
      else if (pick < 9) mode = MODE_HALF;
      else               mode = MODE_SPARE;
      issue_load(ch, slots, rec_len, $urandom, mode);
   endtask

   // mostly the busy pool, sometimes anywhere (usually an unloaded ring)
   function automatic logic [CHAN_W-1:0] pick_channel();
      if ($urandom_range(0, 9) == 0) return CHAN_W'($urandom_range(0, 127));
      return chan_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // reply side: a random hold-off before each reply, then wait for it
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
         while (!rsp_tvalid) @(negedge clock);
         @(posedge clock);
      end
   end

   initial begin
      int          sel;
      logic [AGE_W-1:0] age;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // nothing loaded yet: append and locate must report an unloaded ring
      issue_append(7'd5);
      issue_locate(7'd6, 10'd0, 12'd0);
      issue_nop(7'd0);
      // erase-aware ring of 4 slots, 2 records per block: fills at head 0 and
      // is cut back to slots minus records-per-block
      issue_load(7'd0, 11'd4, 13'd2048, 32'h1000_0000, MODE_ERASE);
      repeat (5) issue_append(7'd0);
      issue_locate(7'd0, 10'd0, 12'd0);
      issue_locate(7'd0, 10'd2, 12'hfff);
      issue_locate(7'd0, 10'd3, 12'd0);        // beyond the valid count
      // slot count zero taken as one, record length zero, address wrap
      issue_load(7'd127, 11'd0, 13'd0, 32'hffff_ffff, MODE_NONE);
      issue_append(7'd127);
      issue_locate(7'd127, 10'd0, 12'hfff);
      // slot count saturates, record longer than a block, spare mode
      issue_load(7'd1, 11'd2047, 13'd8191, 32'h8000_0000, MODE_SPARE);
      issue_append(7'd1);
      issue_locate(7'd1, 10'd0, 12'hfff);
      issue_locate(7'd1, 10'd1023, 12'hfff);
      // half-cap ring: 8 slots, 2 records per block
      issue_load(7'd2, 11'd8, 13'd2048, $urandom, MODE_HALF);
      repeat (6) issue_append(7'd2);
      issue_locate(7'd2, 10'd3, 12'd0);

      // --- random part ---
      foreach (chan_pool[i]) begin
         chan_pool[i] = CHAN_W'($urandom_range(0, 127));
         random_load(chan_pool[i]);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            random_load(pick_channel());
         end else if (sel < 60) begin
            issue_append(pick_channel());
         end else if (sel < 95) begin
            age = ($urandom_range(0, 4) == 0) ? AGE_W'($urandom_range(0, 1023))
                                              : AGE_W'($urandom_range(0, 20));
            issue_locate(pick_channel(), age, OFF_W'($urandom_range(0, 4095)));
         end else begin
            issue_nop(pick_channel());
         end
      end
      req_tvalid <= 1'b0;

      // drain: look after the edge so the last request is already booked,
      // wait for every reply, then a margin for anything stray
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d loads, %0d appends, %0d locates, %0d no-ops",
               n_loads, n_appends, n_locates, n_nops);
      $display("%0d replies compared, %0d mismatches", checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_flash_record_ring_pointer passed");
      end else begin
         $display("tb_flash_record_ring_pointer failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/frrp_pkg.sv
rtl/core/frrp_div.sv
rtl/core/flash_record_ring_pointer.sv
sim/frrp_reply_checker.sv
sim/tb_flash_record_ring_pointer.sv
